// File: rtl/tgm_pkg.sv
// Shared types and constants for the touch gesture to mouse converter.
// No dependencies; imported by every module of the block.
`default_nettype none
package tgm_pkg;

  localparam int unsigned DEF_FINGER_SLOTS  = 3;
  localparam int unsigned DEF_TAP_TIME_MS   = 250;
  localparam int unsigned DEF_TAP_RADIUS_PX = 10;
  localparam int unsigned DEF_CLICK_HOLD_MS = 50;

  localparam int unsigned IN_DATA_W  = 136;
  localparam int unsigned IN_USER_W  = 3;
  localparam int unsigned OUT_DATA_W = 56;
  localparam int unsigned OUT_USER_W = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;

  typedef enum logic [1:0] {
    FUNC_DOWN   = 2'd0,
    FUNC_UP     = 2'd1,
    FUNC_MOTION = 2'd2,
    FUNC_TICK   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    KIND_PRESS   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_MOTION  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    DRAG_IDLE  = 2'd0,
    DRAG_LEFT  = 2'd1,
    DRAG_RIGHT = 2'd2
  } drag_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIRECT_MODE    = 3'd0,
    CFG_VIEW_WIDTH     = 3'd1,
    CFG_VIEW_HEIGHT    = 3'd2,
    CFG_BORDER_X       = 3'd3,
    CFG_BORDER_Y       = 3'd4,
    CFG_SURFACE_WIDTH  = 3'd5,
    CFG_SURFACE_HEIGHT = 3'd6
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_SX,
    ST_MUL_SY,
    ST_MUL_D,
    ST_MUL_E,
    ST_SQ_D,
    ST_SQ_E,
    ST_EVAL,
    ST_SEND0,
    ST_SEND1
  } state_e;

  typedef enum logic [2:0] {
    MOP_NONE,
    MOP_SX,
    MOP_SY,
    MOP_D,
    MOP_E,
    MOP_DD,
    MOP_EE
  } mul_op_e;

  typedef struct packed {
    logic    load;
    mul_op_e mul_op;
    logic    eval;
    logic    sel_second;
  } tgm_cmd_t;

  typedef struct packed {
    logic [1:0] res_cnt;
  } tgm_stat_t;

  typedef struct packed {
    kind_e              kind;
    logic               button;
    logic [11:0]        x;
    logic [11:0]        y;
    logic signed [12:0] rx;
    logic signed [12:0] ry;
  } tgm_res_t;

endpackage
`default_nettype wire

// File: rtl/touch_gesture_to_mouse.sv
// Top level of the touch gesture to mouse converter.
// Instantiates tgm_ctrl and tgm_dp; uses tgm_pkg.
//
// Touch events arrive on the s_axis channel, one event per transfer. Each
// event gives zero, one or two mouse events on the m_axis channel; tlast
// marks the final one of an event. Registers are written through the cfg
// channel, which is always ready; the user must write them only while no
// event is in flight, and the block itself does not enforce it.
// The first result is offered after the six multiplier states and the
// evaluation state. One event is taken at a time; an event occupies the
// block through the six products that run through the single shared
// multiplier, the evaluation step and the transfer of each result.
// s_axis_tready is high only while the block is idle.
// A stalled receiver holds the current result steady and keeps the input
// closed until every result of the event has been taken.
// Reset clears the finger table, drag state, pending clicks and loads the
// register defaults (direct mode, 640 by 480 view and surface, no border).
`default_nettype none
module touch_gesture_to_mouse #(
  parameter int unsigned FINGER_SLOTS  = tgm_pkg::DEF_FINGER_SLOTS,
  parameter int unsigned TAP_TIME_MS   = tgm_pkg::DEF_TAP_TIME_MS,
  parameter int unsigned TAP_RADIUS_PX = tgm_pkg::DEF_TAP_RADIUS_PX,
  parameter int unsigned CLICK_HOLD_MS = tgm_pkg::DEF_CLICK_HOLD_MS
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  // finger_tag, stamp_ms, touch_x, touch_y, move_dx, move_dy, pointer_x, pointer_y
  input  wire  [tgm_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // func, panel
  input  wire  [tgm_pkg::IN_USER_W-1:0]    s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  // out_x, out_y, rel_x, rel_y, zero fill
  output logic [tgm_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // kind, button
  output logic [tgm_pkg::OUT_USER_W-1:0]   m_axis_tuser,
  output logic                             m_axis_tlast,
  input  wire                              cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire  [tgm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire  [tgm_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import tgm_pkg::*;

  tgm_cmd_t  cmd;
  tgm_stat_t stat;
  tgm_res_t  res;
  logic      res_last;

  assign cfg_ready_o = 1'b1;

  tgm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  tgm_dp #(
    .FINGER_SLOTS  (FINGER_SLOTS),
    .TAP_TIME_MS   (TAP_TIME_MS),
    .TAP_RADIUS_PX (TAP_RADIUS_PX),
    .CLICK_HOLD_MS (CLICK_HOLD_MS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .item_data_i (s_axis_tdata),
    .item_user_i (s_axis_tuser),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .res_o       (res),
    .res_last_o  (res_last)
  );

  assign m_axis_tdata = {6'd0, res.ry, res.rx, res.y, res.x};
  assign m_axis_tuser = {res.button, res.kind};
  assign m_axis_tlast = res_last;

endmodule
`default_nettype wire

// File: rtl/tgm_ctrl.sv
// Sequencer of the touch gesture to mouse converter: steps the shared
// multiplier, triggers evaluation and hands results out. Uses tgm_pkg.
`default_nettype none
module tgm_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  input  tgm_pkg::tgm_stat_t   stat_i,
  output tgm_pkg::tgm_cmd_t    cmd_o
);
  import tgm_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_MUL_SX;
      ST_MUL_SX: state_d = ST_MUL_SY;
      ST_MUL_SY: state_d = ST_MUL_D;
      ST_MUL_D:  state_d = ST_MUL_E;
      ST_MUL_E:  state_d = ST_SQ_D;
      ST_SQ_D:   state_d = ST_SQ_E;
      ST_SQ_E:   state_d = ST_EVAL;
      ST_EVAL:   state_d = (stat_i.res_cnt == 2'd0) ? ST_IDLE : ST_SEND0;
      ST_SEND0: begin
        if (out_ready_i) state_d = (stat_i.res_cnt == 2'd2) ? ST_SEND1 : ST_IDLE;
      end
      ST_SEND1:  if (out_ready_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o        = 1'b0;
    out_valid_o       = 1'b0;
    cmd_o.load        = 1'b0;
    cmd_o.mul_op      = MOP_NONE;
    cmd_o.eval        = 1'b0;
    cmd_o.sel_second  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_MUL_SX: cmd_o.mul_op = MOP_SX;
      ST_MUL_SY: cmd_o.mul_op = MOP_SY;
      ST_MUL_D:  cmd_o.mul_op = MOP_D;
      ST_MUL_E:  cmd_o.mul_op = MOP_E;
      ST_SQ_D:   cmd_o.mul_op = MOP_DD;
      ST_SQ_E:   cmd_o.mul_op = MOP_EE;
      ST_EVAL:   cmd_o.eval = 1'b1;
      ST_SEND0:  out_valid_o = 1'b1;
      ST_SEND1: begin
        out_valid_o      = 1'b1;
        cmd_o.sel_second = 1'b1;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/tgm_dp.sv
// Datapath of the touch gesture to mouse converter: configuration, finger
// slot table, shared multiplier, gesture evaluation and result registers.
// Uses tgm_pkg.
`default_nettype none
module tgm_dp #(
  parameter int unsigned FINGER_SLOTS  = tgm_pkg::DEF_FINGER_SLOTS,
  parameter int unsigned TAP_TIME_MS   = tgm_pkg::DEF_TAP_TIME_MS,
  parameter int unsigned TAP_RADIUS_PX = tgm_pkg::DEF_TAP_RADIUS_PX,
  parameter int unsigned CLICK_HOLD_MS = tgm_pkg::DEF_CLICK_HOLD_MS
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               cfg_we_i,
  input  wire  [tgm_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire  [tgm_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire  [tgm_pkg::IN_DATA_W-1:0]     item_data_i,
  input  wire  [tgm_pkg::IN_USER_W-1:0]     item_user_i,
  input  tgm_pkg::tgm_cmd_t                 cmd_i,
  output tgm_pkg::tgm_stat_t                stat_o,
  output tgm_pkg::tgm_res_t                 res_o,
  output logic                              res_last_o
);
  import tgm_pkg::*;

  localparam int unsigned CntW = $clog2(FINGER_SLOTS + 1);
  localparam logic [31:0] TapT  = 32'(TAP_TIME_MS);
  localparam logic [31:0] HoldT = 32'(CLICK_HOLD_MS);
  localparam logic [58:0] RadLim = 59'(TAP_RADIUS_PX * TAP_RADIUS_PX) << 32;

  // Configuration
  logic        direct_q;
  logic [11:0] vw_q, vh_q, bx_q, by_q, sw_q, sh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      direct_q <= 1'b1;
      vw_q     <= 12'd640;
      vh_q     <= 12'd480;
      bx_q     <= 12'd0;
      by_q     <= 12'd0;
      sw_q     <= 12'd640;
      sh_q     <= 12'd480;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_DIRECT_MODE:    direct_q <= cfg_data_i[0];
        CFG_VIEW_WIDTH:     vw_q     <= cfg_data_i;
        CFG_VIEW_HEIGHT:    vh_q     <= cfg_data_i;
        CFG_BORDER_X:       bx_q     <= cfg_data_i;
        CFG_BORDER_Y:       by_q     <= cfg_data_i;
        CFG_SURFACE_WIDTH:  sw_q     <= cfg_data_i;
        CFG_SURFACE_HEIGHT: sh_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Captured item
  logic [IN_DATA_W-1:0] item_q;
  logic [IN_USER_W-1:0] user_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= item_data_i;
      user_q <= item_user_i;
    end
  end

  func_e              func;
  logic               panel;
  logic [15:0]        tag;
  logic [31:0]        stamp;
  logic [15:0]        tx, ty;
  logic signed [15:0] mdx, mdy;
  logic [11:0]        px, py;

  assign func  = func_e'(user_q[1:0]);
  assign panel = user_q[2];
  assign tag   = item_q[15:0];
  assign stamp = item_q[47:16];
  assign tx    = item_q[63:48];
  assign ty    = item_q[79:64];
  assign mdx   = $signed(item_q[95:80]);
  assign mdy   = $signed(item_q[111:96]);
  assign px    = item_q[123:112];
  assign py    = item_q[135:124];

  // Slot table
  logic [FINGER_SLOTS-1:0] busy_q, busy_d;
  logic [15:0]             s_tag_q   [FINGER_SLOTS];
  logic [31:0]             s_time_q  [FINGER_SLOTS];
  logic [15:0]             s_dx_q    [FINGER_SLOTS];
  logic [15:0]             s_dy_q    [FINGER_SLOTS];
  logic [11:0]             s_px_q    [FINGER_SLOTS];
  logic [11:0]             s_py_q    [FINGER_SLOTS];
  logic [FINGER_SLOTS-1:0] new_we, pos_we;
  logic [11:0]             new_x, new_y, mot_x, mot_y;

  logic [1:0]  drag_q, drag_d;
  logic [1:0]  pend_q, pend_d;
  logic [31:0] start_q [2];
  logic [31:0] start_d [2];

  // Matching slot, first one wins
  logic [FINGER_SLOTS-1:0] tag_hit, self_oh;
  logic                    self_found;
  logic [15:0]             self_dx, self_dy;
  logic [31:0]             self_time;
  logic [CntW-1:0]         cnt;

  always_comb begin
    self_oh    = '0;
    self_found = 1'b0;
    self_dx    = '0;
    self_dy    = '0;
    self_time  = '0;
    cnt        = '0;
    for (int i = 0; i < FINGER_SLOTS; i++) begin
      tag_hit[i] = busy_q[i] && (s_tag_q[i] == tag);
      if (tag_hit[i] && !self_found) begin
        self_oh[i] = 1'b1;
        self_found = 1'b1;
      end
      if (busy_q[i]) cnt = cnt + CntW'(1);
    end
    for (int i = 0; i < FINGER_SLOTS; i++) begin
      if (self_oh[i]) begin
        self_dx   = s_dx_q[i];
        self_dy   = s_dy_q[i];
        self_time = s_time_q[i];
      end
    end
  end

  // Shared multiplier, one product per cycle
  logic signed [29:0] mul_a, mul_b;
  logic signed [59:0] prod;
  logic [27:0]        sx_q, sy_q;
  logic signed [28:0] d_q, e_q;
  logic [57:0]        dd_q, ee_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul_op)
      MOP_SX: begin
        mul_a = $signed({14'd0, tx});
        mul_b = $signed({18'd0, vw_q});
      end
      MOP_SY: begin
        mul_a = $signed({14'd0, ty});
        mul_b = $signed({18'd0, vh_q});
      end
      MOP_D: begin
        mul_a = (func == FUNC_MOTION) ? 30'(mdx)
                                      : $signed({14'd0, tx}) - $signed({14'd0, self_dx});
        mul_b = $signed({18'd0, sw_q});
      end
      MOP_E: begin
        mul_a = (func == FUNC_MOTION) ? 30'(mdy)
                                      : $signed({14'd0, ty}) - $signed({14'd0, self_dy});
        mul_b = $signed({18'd0, sh_q});
      end
      MOP_DD: begin
        mul_a = 30'(d_q);
        mul_b = 30'(d_q);
      end
      MOP_EE: begin
        mul_a = 30'(e_q);
        mul_b = 30'(e_q);
      end
      default: ;
    endcase
  end

  assign prod = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    case (cmd_i.mul_op)
      MOP_SX:  sx_q <= prod[27:0];
      MOP_SY:  sy_q <= prod[27:0];
      MOP_D:   d_q  <= prod[28:0];
      MOP_E:   e_q  <= prod[28:0];
      MOP_DD:  dd_q <= prod[57:0];
      MOP_EE:  ee_q <= prod[57:0];
      default: ;
    endcase
  end

  // Scaling and relative motion
  function automatic logic [11:0] sat_add(input logic [11:0] a, input logic [11:0] b);
    logic [12:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[12] ? 12'hFFF : s[11:0];
  endfunction

  function automatic logic [11:0] clip(input logic [13:0] v, input logic [11:0] lim);
    return (v > {2'b0, lim}) ? lim : v[11:0];
  endfunction

  function automatic logic [11:0] rel(input logic [11:0] ptr, input logic signed [28:0] d,
                                      input logic [11:0] lim);
    logic signed [34:0] num;
    num = $signed({6'd0, ptr, 17'd0}) + (35'(d) <<< 2) + 35'(d);
    return num[34] ? 12'd0 : clip(num[30:17], lim);
  endfunction

  logic [11:0]        scl_x, scl_y;
  logic signed [12:0] rx, ry;
  logic               still;

  assign scl_x = sat_add(sx_q[27:16], bx_q);
  assign scl_y = sat_add(sy_q[27:16], by_q);
  assign new_x = direct_q ? scl_x : px;
  assign new_y = direct_q ? scl_y : py;
  assign mot_x = direct_q ? clip({2'b0, scl_x}, sw_q) : rel(px, d_q, sw_q);
  assign mot_y = direct_q ? clip({2'b0, scl_y}, sh_q) : rel(py, e_q, sh_q);
  assign rx    = $signed({1'b0, mot_x}) - $signed({1'b0, px});
  assign ry    = $signed({1'b0, mot_y}) - $signed({1'b0, py});
  assign still = ({1'b0, dd_q} + {1'b0, ee_q}) < RadLim;

  function automatic tgm_res_t mk(input kind_e k, input logic b, input logic [11:0] x,
                                  input logic [11:0] y, input logic signed [12:0] rxv,
                                  input logic signed [12:0] ryv);
    tgm_res_t r;
    r.kind   = k;
    r.button = b;
    r.x      = x;
    r.y      = y;
    r.rx     = rxv;
    r.ry     = ryv;
    return r;
  endfunction

  // Evaluation of one item
  tgm_res_t r0_d, r1_d, r0_q, r1_q;
  logic [1:0] n_d, n_q;

  always_comb begin
    logic [FINGER_SLOTS-1:0] busy_t;
    logic                    found;
    logic [CntW-1:0]         longc;
    logic [31:0]             early;
    logic [11:0]             dx0, dy0;
    logic                    oldest;
    tgm_res_t                v;
    busy_d   = busy_q;
    drag_d   = drag_q;
    pend_d   = pend_q;
    start_d  = start_q;
    new_we   = '0;
    pos_we   = '0;
    r0_d     = '0;
    r1_d     = '0;
    n_d      = 2'd0;
    busy_t   = busy_q;
    found    = 1'b0;
    longc    = '0;
    early    = self_time;
    dx0      = px;
    dy0      = py;
    oldest   = 1'b1;
    v        = '0;
    if (func == FUNC_TICK) begin
      for (int b = 0; b < 2; b++) begin
        if (pend_q[b] && ((stamp - start_q[b]) >= HoldT)) begin
          v = mk(KIND_RELEASE, b[0], px, py, 13'sd0, 13'sd0);
          if (n_d == 2'd0) r0_d = v;
          else r1_d = v;
          n_d        = n_d + 2'd1;
          pend_d[b]  = 1'b0;
          start_d[b] = '0;
        end
      end
    end else if (!panel) begin
      case (func)
        FUNC_DOWN: begin
          busy_t = busy_q & ~tag_hit;
          busy_d = busy_t;
          for (int i = 0; i < FINGER_SLOTS; i++) begin
            if (!found && !busy_t[i]) begin
              found     = 1'b1;
              busy_d[i] = 1'b1;
              new_we[i] = 1'b1;
            end
          end
        end
        FUNC_UP: begin
          if (self_found) begin
            busy_d = busy_q & ~self_oh;
            if (drag_q == DRAG_IDLE) begin
              if (((stamp - self_time) <= TapT) && still) begin
                if (cnt == CntW'(2)) begin
                  pend_d[1]  = 1'b1;
                  start_d[1] = stamp;
                  r0_d       = mk(KIND_PRESS, 1'b1, px, py, 13'sd0, 13'sd0);
                  n_d        = 2'd1;
                end else if (cnt == CntW'(1)) begin
                  pend_d[0]  = 1'b1;
                  start_d[0] = stamp;
                  r0_d       = mk(KIND_PRESS, 1'b0, new_x, new_y, 13'sd0, 13'sd0);
                  n_d        = 2'd1;
                end
              end
            end else if (cnt == CntW'(1)) begin
              r0_d   = mk(KIND_RELEASE, (drag_q == DRAG_RIGHT), px, py, 13'sd0, 13'sd0);
              n_d    = 2'd1;
              drag_d = DRAG_IDLE;
            end
          end
        end
        FUNC_MOTION: begin
          if (cnt != '0) begin
            pos_we = tag_hit;
            for (int i = 0; i < FINGER_SLOTS; i++) begin
              if (busy_q[i] && ((stamp - s_time_q[i]) > TapT)) longc = longc + CntW'(1);
              // Chain over the other fingers keeps the earliest one down.
              if (busy_q[i] && !self_oh[i] && (s_time_q[i] < early)) begin
                dx0   = s_px_q[i];
                dy0   = s_py_q[i];
                early = s_time_q[i];
              end
              if (busy_q[i] && !self_oh[i] && (s_time_q[i] < self_time)) oldest = 1'b0;
            end
            if (!(direct_q && self_found)) begin
              dx0 = px;
              dy0 = py;
            end
            if (!((cnt > CntW'(1)) && self_found)) oldest = 1'b1;
            if ((rx != 13'sd0 || ry != 13'sd0) && oldest) begin
              r0_d = mk(KIND_MOTION, 1'b0, mot_x, mot_y, rx, ry);
              n_d  = 2'd1;
            end
            if ((cnt >= CntW'(2)) && (drag_q == DRAG_IDLE) && (longc >= CntW'(2))) begin
              v      = mk(KIND_PRESS, (longc != CntW'(2)), dx0, dy0, 13'sd0, 13'sd0);
              drag_d = (longc == CntW'(2)) ? DRAG_LEFT : DRAG_RIGHT;
              if (n_d == 2'd0) r0_d = v;
              else r1_d = v;
              n_d = n_d + 2'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= '0;
      drag_q     <= DRAG_IDLE;
      pend_q     <= '0;
      start_q[0] <= '0;
      start_q[1] <= '0;
      n_q        <= 2'd0;
    end else if (cmd_i.eval) begin
      busy_q  <= busy_d;
      drag_q  <= drag_d;
      pend_q  <= pend_d;
      start_q <= start_d;
      n_q     <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      r0_q <= r0_d;
      r1_q <= r1_d;
      for (int i = 0; i < FINGER_SLOTS; i++) begin
        if (new_we[i]) begin
          s_tag_q[i]  <= tag;
          s_time_q[i] <= stamp;
          s_dx_q[i]   <= tx;
          s_dy_q[i]   <= ty;
          s_px_q[i]   <= new_x;
          s_py_q[i]   <= new_y;
        end else if (pos_we[i]) begin
          s_px_q[i]   <= mot_x;
          s_py_q[i]   <= mot_y;
        end
      end
    end
  end

  // After evaluation the table has moved on, so the stored count is reported.
  assign stat_o.res_cnt = cmd_i.eval ? n_d : n_q;
  assign res_o          = cmd_i.sel_second ? r1_q : r0_q;
  assign res_last_o     = cmd_i.sel_second || (n_q == 2'd1);

endmodule
`default_nettype wire

// File: rtl/tgm_checker.sv
// Port-level checks for touch_gesture_to_mouse, bound to the top level.
// Uses tgm_pkg for port widths.
`default_nettype none
module tgm_checker (
  input wire                              clk_i,
  input wire                              rst_ni,
  input wire                              s_axis_tvalid,
  input wire                              s_axis_tready,
  input wire                              m_axis_tvalid,
  input wire                              m_axis_tready,
  input wire [tgm_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  input wire [tgm_pkg::OUT_USER_W-1:0]    m_axis_tuser,
  input wire                              m_axis_tlast
);
  import tgm_pkg::*;

  // A result held back by the receiver must not change.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // One event at a time: the input is closed while results are offered.
  a_excl: assert property (@(posedge clk_i) !(s_axis_tready && m_axis_tvalid))
    else $error("input open while a result is offered");

  // An accepted event needs several cycles before its first result.
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid ##1 !m_axis_tvalid)
    else $error("result too early after an input transfer");

  // A press or release never carries a relative motion.
  a_btn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser[1:0] != KIND_MOTION) |-> m_axis_tdata[49:24] == 26'd0)
    else $error("button result with motion");

endmodule

bind touch_gesture_to_mouse tgm_checker u_tgm_checker (.*);
`default_nettype wire
